[rtl/mab_pkg.sv]
`default_nettype none

package mab_pkg;

   // Command codes of an input item.
   localparam logic CMD_ALLOCATE = 1'b0;
   localparam logic CMD_REWIND   = 1'b1;

   // Result status codes.
   localparam logic [1:0] ST_ALLOCATED = 2'd0;
   localparam logic [1:0] ST_TOO_LARGE = 2'd1;
   localparam logic [1:0] ST_REWOUND   = 2'd2;
   localparam logic [1:0] ST_HELD_OFF  = 2'd3;

   // Configuration register map (word index within the register file).
   localparam int          CSR_ADDR_WIDTH = 3;
   localparam logic        REG_HOLD_RESET = 1'b0;

   typedef struct packed {
      logic        command;
      logic [15:0] request_size;
   } req_type;

   typedef struct packed {
      logic [15:0] address;
      logic [2:0]  arena_index;
      logic [1:0]  status;
   } rsp_type;

endpackage

`default_nettype wire

[rtl/multi_arena_bump_allocator_core.sv]
`default_nettype none

// Bump allocator over a row of NUM_ARENAS arenas whose sizes double: arena i
// holds BASE_ARENA_BYTES << i bytes and the arenas lie end to end in one
// global byte space. Start an item by raising start; busy is always low, so
// one item is taken on every clock cycle in which start is high. Each item
// produces exactly one result, shown on rsp_item for a single cycle with
// rsp_valid high, and results leave in the order the items came in. The
// receiver cannot stall the block and must take every result in the cycle
// it appears. The block is a three-register pipeline: the first stage
// multiplies the padded size by the reciprocal of the alignment, the second
// finishes the round-up with one compare and correction, and the third
// compares the rounded size against every arena in parallel, picks the
// lowest one that fits and updates the fill offsets in the same cycle, so
// back-to-back items always see each other's effect. The hold_reset
// register (word index 0) turns rewind items into no-ops that report a
// held-off status; write it only while no item is in flight.
module multi_arena_bump_allocator_core #(
   parameter int NUM_ARENAS       = 8,
   parameter int BASE_ARENA_BYTES = 256,
   parameter int ALIGN_BYTES      = 4
) (
   input  wire                                    clock,
   input  wire                                    reset,

   input  wire                                    start,
   output logic                                   busy,
   input  wire  mab_pkg::req_type                 req_item,

   output logic                                   rsp_valid,
   output mab_pkg::rsp_type                       rsp_item,

   input  wire                                    psel,
   input  wire                                    penable,
   input  wire                                    pwrite,
   input  wire  [mab_pkg::CSR_ADDR_WIDTH-1:0]     paddr,
   input  wire  [31:0]                            pwdata,
   output logic [31:0]                            prdata,
   output logic                                   pready
);

   import mab_pkg::*;

   // Width of a rounded size: 65535 rounded up can reach 65536.
   localparam int SW    = 17;
   // Fixed-point shift and reciprocal for the division by the alignment.
   localparam int SHIFT = 22;
   localparam int PW    = SW + SHIFT;
   localparam longint RECIP = (64'd1 << SHIFT) / ALIGN_BYTES;
   // Fill offsets must hold the capacity of the largest arena and be able
   // to compare against any rounded size.
   localparam int CW0   = $clog2(BASE_ARENA_BYTES) + NUM_ARENAS;
   localparam int CW    = (CW0 > SW) ? CW0 : SW;
   localparam int IW    = $clog2(NUM_ARENAS);

   // Lower 16 bits of the global start address of arena i.
   function automatic logic [15:0] arena_base(input int i);
      logic [63:0] full;
      full = 64'(BASE_ARENA_BYTES) * ((64'd1 << i) - 64'd1);
      return full[15:0];
   endfunction

   //------------------------------------------------------------------------
   // Configuration port
   //------------------------------------------------------------------------
   logic hold_reset_ff;
   logic csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready
                      && (paddr[CSR_ADDR_WIDTH-1] == REG_HOLD_RESET);

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_reset_ff <= 1'b0;
      end else if (csr_write) begin
         hold_reset_ff <= pwdata[0];
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[CSR_ADDR_WIDTH-1] == REG_HOLD_RESET) begin
         prdata[0] = hold_reset_ff;
      end
   end

   //------------------------------------------------------------------------
   // Stage 1: pad the size and multiply by the reciprocal of the alignment.
   //------------------------------------------------------------------------
   logic          accept;
   logic          s1_valid_ff;
   logic          s1_command_ff;
   logic [SW-1:0] s1_padded_ff;
   logic [PW-1:0] s1_product_ff;
   logic [SW-1:0] padded_in;

   assign busy      = 1'b0;
   assign accept    = start && !busy;
   assign padded_in = SW'(req_item.request_size) + SW'(ALIGN_BYTES - 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
      s1_command_ff <= req_item.command;
      s1_padded_ff  <= padded_in;
      s1_product_ff <= PW'(padded_in) * PW'(RECIP);
   end

   //------------------------------------------------------------------------
   // Stage 2: the estimated quotient is exact or one short; one compare
   // against the alignment fixes it.
   //------------------------------------------------------------------------
   logic            s2_valid_ff;
   logic            s2_command_ff;
   logic [SW-1:0]   s2_size_ff;
   logic [SW-1:0]   quot_est;
   logic [SW:0]     rounded_est;
   logic [SW:0]     remainder;
   logic [SW:0]     rounded_in;

   always_comb begin
      quot_est    = s1_product_ff[PW-1:SHIFT];
      rounded_est = (SW+1)'(quot_est) * (SW+1)'(ALIGN_BYTES);
      remainder   = (SW+1)'(s1_padded_ff) - rounded_est;
      if (remainder >= (SW+1)'(ALIGN_BYTES)) begin
         rounded_in = rounded_est + (SW+1)'(ALIGN_BYTES);
      end else begin
         rounded_in = rounded_est;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      s2_command_ff <= s1_command_ff;
      s2_size_ff    <= rounded_in[SW-1:0];
   end

   //------------------------------------------------------------------------
   // Stage 3: parallel fit test over all arenas, lowest-index pick, and the
   // state update. The fit test for an open arena also checks that its fill
   // offset has not passed the capacity.
   //------------------------------------------------------------------------
   logic [NUM_ARENAS-1:0]         arena_open_ff;
   logic [NUM_ARENAS-1:0]         arena_open_in;
   logic [NUM_ARENAS-1:0][CW-1:0] arena_used_ff;
   logic [NUM_ARENAS-1:0][CW-1:0] arena_used_in;
   logic [NUM_ARENAS-1:0]         fits;
   logic                          found;
   logic [IW-1:0]                 pick;
   logic [15:0]                   base_sel;
   logic [CW-1:0]                 used_sel;
   logic [CW-1:0]                 size_ext;
   logic [CW-1:0]                 cap;
   logic                          rsp_valid_ff;
   rsp_type                       rsp_item_ff;
   rsp_type                       rsp_item_in;

   always_comb begin
      size_ext = CW'(s2_size_ff);
      for (int i = 0; i < NUM_ARENAS; i++) begin
         cap = CW'(BASE_ARENA_BYTES) << i;
         if (arena_open_ff[i]) begin
            fits[i] = (arena_used_ff[i] <= cap)
                      && ((cap - arena_used_ff[i]) >= size_ext);
         end else begin
            fits[i] = (cap >= size_ext);
         end
      end

      found = 1'b0;
      pick  = '0;
      for (int i = NUM_ARENAS - 1; i >= 0; i--) begin
         if (fits[i]) begin
            found = 1'b1;
            pick  = IW'(i);
         end
      end

      // A newly opened arena starts from an empty fill offset.
      base_sel = '0;
      used_sel = '0;
      for (int i = 0; i < NUM_ARENAS; i++) begin
         if (IW'(i) == pick) begin
            base_sel = arena_base(i);
            used_sel = arena_open_ff[i] ? arena_used_ff[i] : '0;
         end
      end

      arena_open_in = arena_open_ff;
      arena_used_in = arena_used_ff;
      rsp_item_in   = '0;

      if (s2_command_ff == CMD_REWIND) begin
         if (hold_reset_ff) begin
            rsp_item_in.status = ST_HELD_OFF;
         end else begin
            for (int i = 0; i < NUM_ARENAS; i++) begin
               if (arena_open_ff[i]) begin
                  arena_used_in[i] = '0;
               end
            end
            rsp_item_in.status = ST_REWOUND;
         end
      end else if (!found) begin
         rsp_item_in.status = ST_TOO_LARGE;
      end else begin
         for (int i = 0; i < NUM_ARENAS; i++) begin
            if (IW'(i) == pick) begin
               arena_open_in[i] = 1'b1;
               arena_used_in[i] = used_sel + size_ext;
            end
         end
         rsp_item_in.address     = base_sel + used_sel[15:0];
         rsp_item_in.arena_index = 3'(pick);
         rsp_item_in.status      = ST_ALLOCATED;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         arena_open_ff <= '0;
         arena_used_ff <= '0;
      end else begin
         rsp_valid_ff <= s2_valid_ff;
         if (s2_valid_ff) begin
            arena_open_ff <= arena_open_in;
            arena_used_ff <= arena_used_in;
         end
      end
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   //------------------------------------------------------------------------
   // Assertions
   //------------------------------------------------------------------------
`ifndef SYNTHESIS
   // Every accepted item yields its result strobe through the pipeline registers.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##3 rsp_valid)
      else $error("result strobe missing three cycles after an accepted item");

   // Only an allocation carries an address or an arena index.
   a_no_alloc_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.status != ST_ALLOCATED)
      |-> (rsp_item.address == 16'd0 && rsp_item.arena_index == 3'd0))
      else $error("non-allocation result carries address or arena index");

   // A held-off rewind leaves the fill offsets and open flags untouched.
   a_held_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.status == ST_HELD_OFF)
      |-> (arena_used_ff == $past(arena_used_ff)
           && arena_open_ff == $past(arena_open_ff)))
      else $error("held-off rewind changed arena state");

   // A completed rewind is only reported while the hold register is clear.
   a_rewind_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.status == ST_REWOUND) |-> !hold_reset_ff)
      else $error("rewind completed while hold_reset was set");
`endif

endmodule

`default_nettype wire
